// ===== rtl/core/bmpq_pkg.sv =====
package bmpq_pkg;

    localparam int PRIO_W        = 8;
    localparam int DATA_W        = 32;
    localparam int DEFAULT_DEPTH = 16;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // One slot of the sorted chain, as seen by its neighbors.
    typedef struct packed
    {
        logic              valid;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
        logic              keep;   // slot stays put on an insert
    } slot_t;

    // Command broadcast to every cell.
    typedef struct packed
    {
        logic              insert;
        logic              remove;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } cmd_t;

endpackage

// ===== rtl/core/bounded_min_priority_queue.sv =====
// Bounded min priority queue built as a sorted chain of DEPTH cells.
// The result of each input transfer is captured in the output register.
// Throughput: one item per cycle unless a held result drops in_ready; every cell
// updates in parallel, so an insert or a remove costs the same at any occupancy.
// Reset (rst_n, async, active low) empties the chain and the output register.
module bounded_min_priority_queue
#(
    parameter int DEPTH = bmpq_pkg::DEFAULT_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic [bmpq_pkg::PRIO_W-1:0]       priority_req,
    input  logic signed [bmpq_pkg::DATA_W-1:0] payload,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [bmpq_pkg::PRIO_W-1:0]       out_priority,
    output logic signed [bmpq_pkg::DATA_W-1:0] out_payload,
    output logic [$clog2(DEPTH+1)-1:0]        occupancy
);
    import bmpq_pkg::*;

    localparam int OccW = $clog2(DEPTH + 1);

    // Slot 0 is the head: the next entry to leave. The chain stays sorted by
    // priority with ties in arrival order, so a remove simply pops slot 0.
    slot_t            slots [DEPTH];
    slot_t            head_slot;
    slot_t            tail_slot;
    cmd_t             cmd;

    logic             in_fire;
    logic             full;
    logic             empty;
    logic             do_insert;
    logic             do_remove;

    logic [OccW-1:0]  count_reg;
    logic [OccW-1:0]  count_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          status_reg;
    status_t          status_next;
    logic [PRIO_W-1:0] out_prio_reg;
    logic [PRIO_W-1:0] out_prio_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] out_data_next;
    logic [OccW-1:0]  occ_reg;

    // Accept a new item whenever the output register is free or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Occupancy is visible at the chain ends: the last slot for full, the
    // head for empty.
    assign full  = slots[DEPTH-1].valid;
    assign empty = !slots[0].valid;

    assign do_insert = in_fire && (op_t'(operation) == OP_INSERT) && !full;
    assign do_remove = in_fire && (op_t'(operation) == OP_REMOVE) && !empty;

    assign cmd.insert = do_insert;
    assign cmd.remove = do_remove;
    assign cmd.prio   = priority_req;
    assign cmd.data   = DATA_W'(payload);

    // Boundary neighbors: in front of the head everything "stays", so the head
    // takes a new entry that beats it; behind the tail only empty slots arrive.
    assign head_slot = '{valid: 1'b1, prio: '0, data: '0, keep: 1'b1};
    assign tail_slot = '{valid: 1'b0, prio: '0, data: '0, keep: 1'b0};

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        bmpq_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  ((i == 0) ? head_slot : slots[(i == 0) ? 0 : i - 1]),
            .right ((i == DEPTH - 1) ? tail_slot : slots[(i == DEPTH - 1) ? i : i + 1]),
            .slot  (slots[i])
        );
    end

    // Track occupancy alongside the chain for the result field.
    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + OccW'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - OccW'(1);
        end
    end

    // Build the result of the item being transferred in.
    always_comb
    begin
        status_next    = STATUS_OK;
        out_prio_next  = '0;
        out_data_next  = '0;
        if (op_t'(operation) == OP_INSERT)
        begin
            if (full)
            begin
                status_next = STATUS_FULL;
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = STATUS_EMPTY;
            end
            else
            begin
                out_prio_next = slots[0].prio;
                out_data_next = slots[0].data;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: hold until the next input transfer.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg   <= status_next;
            out_prio_reg <= out_prio_next;
            out_data_reg <= out_data_next;
            occ_reg      <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = 2'(status_reg);
    assign out_priority = out_prio_reg;
    assign out_payload  = $signed(out_data_reg);
    assign occupancy    = occ_reg;

endmodule

// ===== rtl/core/bmpq_cell.sv =====
module bmpq_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  bmpq_pkg::cmd_t  cmd,
    input  bmpq_pkg::slot_t left,
    input  bmpq_pkg::slot_t right,
    output bmpq_pkg::slot_t slot
);
    import bmpq_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              keep;

    // Stay when holding an entry of equal or smaller priority: ties keep order.
    assign keep = valid_reg && (prio_reg <= cmd.prio);

    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        data_next  = data_reg;
        if (cmd.insert && !keep)
        begin
            if (left.keep)
            begin
                // first slot past the insertion point: take the new entry
                valid_next = 1'b1;
                prio_next  = cmd.prio;
                data_next  = cmd.data;
            end
            else
            begin
                // shift toward the tail
                valid_next = left.valid;
                prio_next  = left.prio;
                data_next  = left.data;
            end
        end
        else if (cmd.remove)
        begin
            // shift toward the head
            valid_next = right.valid;
            prio_next  = right.prio;
            data_next  = right.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

    assign slot.valid = valid_reg;
    assign slot.prio  = prio_reg;
    assign slot.data  = data_reg;
    assign slot.keep  = keep;

endmodule

// ===== rtl/core/bmpq_checker.sv =====
module bmpq_checker
#(
    parameter int DEPTH = bmpq_pkg::DEFAULT_DEPTH
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               operation,
    input logic [bmpq_pkg::PRIO_W-1:0]        priority_req,
    input logic signed [bmpq_pkg::DATA_W-1:0] payload,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [1:0]                         status,
    input logic [bmpq_pkg::PRIO_W-1:0]        out_priority,
    input logic signed [bmpq_pkg::DATA_W-1:0] out_payload,
    input logic [$clog2(DEPTH+1)-1:0]         occupancy
);
    import bmpq_pkg::*;

    localparam int OccW = $clog2(DEPTH + 1);

    // Hold a stalled input transfer.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(operation) && $stable(priority_req)
            && $stable(payload))
        else $error("input changed while stalled");

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy)
            && $stable(out_payload))
        else $error("result changed while stalled");

    // A dropped insert only happens at full occupancy.
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == 2'(STATUS_FULL)) |-> occupancy == OccW'(DEPTH))
        else $error("full status with occupancy below depth");

    // An empty remove only happens with nothing stored.
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == 2'(STATUS_EMPTY)) |-> occupancy == '0)
        else $error("empty status with entries stored");

    // Failed items return no entry.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != 2'(STATUS_OK)) |-> (out_priority == '0) && (out_payload == '0))
        else $error("failed item returned entry data");

endmodule

bind bounded_min_priority_queue bmpq_checker #(.DEPTH(DEPTH)) u_bmpq_checker (.*);

// ===== bench/tb_bounded_min_priority_queue.sv =====
`timescale 1ns / 100ps

module tb_bounded_min_priority_queue;

    import bmpq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AFTER  = 100;   // transfers accepted before the long receiver stall
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_CAP   = 40;

    // One request as the sender offers it, with the idle cycles to wait before it.
    typedef struct {
        op_t                      op;
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] data;
        int unsigned              lead;
    } queue_req_t;

    // One result as the block should return it.
    typedef struct {
        status_t                  status;
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] data;
        logic [OCC_W-1:0]         occ;
    } queue_resp_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      operation = 1'b0;
    logic [PRIO_W-1:0]         priority_req = '0;
    logic signed [DATA_W-1:0]  payload = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [1:0]                status;
    logic [PRIO_W-1:0]         out_priority;
    logic signed [DATA_W-1:0]  out_payload;
    logic [OCC_W-1:0]          occupancy;

    // Sender side: requests still to be offered and the one on the bus now.
    queue_req_t  outgoing_items[$];
    queue_req_t  live_item;
    int unsigned lead_count = 0;
    int unsigned accepted_count = 0;

    // Results owed by the block, oldest first.
    queue_resp_t due_results[$];
    queue_resp_t rx_want;
    int unsigned rx_wait = 0;
    int unsigned result_count = 0;

    // Long receiver stall, driven by its own counter.
    logic        rx_hold = 1'b0;
    logic        rx_hold_done = 1'b0;
    int unsigned rx_hold_cycles = 0;

    // Our copy of the sorted chain: slot 0 leaves next.
    logic [PRIO_W-1:0]        chain_prio[DEPTH];
    logic signed [DATA_W-1:0] chain_data[DEPTH];
    int                       chain_count = 0;

    int mismatch_count = 0;
    int cycle_count = 0;

    bounded_min_priority_queue #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .priority_req (priority_req),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_priority (out_priority),
        .out_payload  (out_payload),
        .occupancy    (occupancy)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        begin
            if (mismatch_count < PRINT_CAP)
                $display("%0t mismatch: %s", $time, what);
            mismatch_count++;
        end
    endtask

    function automatic void push_request(op_t op, logic [PRIO_W-1:0] prio,
                                         logic signed [DATA_W-1:0] data, int unsigned lead);
        queue_req_t req;
        req.op   = op;
        req.prio = prio;
        req.data = data;
        req.lead = lead;
        outgoing_items.push_back(req);
    endfunction

    // Apply one request to the chain copy and return the result it must produce.
    // A new entry goes behind every stored entry of equal or smaller priority, so
    // ties leave in arrival order.
    function automatic queue_resp_t predict_queue_result(queue_req_t req);
        queue_resp_t resp;
        int          pos;
        int          i;
        resp.status = STATUS_OK;
        resp.prio   = '0;
        resp.data   = '0;
        if (req.op == OP_INSERT)
        begin
            if (chain_count >= DEPTH)
                resp.status = STATUS_FULL;
            else
            begin
                pos = 0;
                while (pos < chain_count && chain_prio[pos] <= req.prio)
                    pos++;
                for (i = chain_count; i > pos; i--)
                begin
                    chain_prio[i] = chain_prio[i - 1];
                    chain_data[i] = chain_data[i - 1];
                end
                chain_prio[pos] = req.prio;
                chain_data[pos] = req.data;
                chain_count++;
            end
        end
        else if (chain_count == 0)
            resp.status = STATUS_EMPTY;
        else
        begin
            resp.prio = chain_prio[0];
            resp.data = chain_data[0];
            for (i = 0; i + 1 < chain_count; i++)
            begin
                chain_prio[i] = chain_prio[i + 1];
                chain_data[i] = chain_data[i + 1];
            end
            chain_count--;
        end
        resp.occ = OCC_W'(chain_count);
        return resp;
    endfunction

    // Driver: record each accepted transfer's expected result, then hold the
    // current request, idle for the next one's lead, or present the next one.
    // in_valid gets at most one assignment per edge, so back-to-back transfers
    // keep it high without a glitch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            operation    <= OP_INSERT;
            priority_req <= '0;
            payload      <= '0;
            lead_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                due_results.push_back(predict_queue_result(live_item));
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (outgoing_items.size() > 0 && lead_count >= outgoing_items[0].lead)
                begin
                    live_item = outgoing_items.pop_front();
                    in_valid     <= 1'b1;
                    operation    <= live_item.op;
                    priority_req <= live_item.prio;
                    payload      <= live_item.data;
                    lead_count = 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (outgoing_items.size() > 0)
                        lead_count++;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest owed result, field by
    // field, then draw the stall before the next one. Every third window of 64
    // results runs with no stall at all.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                    flag_mismatch("result transfer with nothing owed");
                else
                begin
                    rx_want = due_results.pop_front();
                    if (status !== rx_want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                status, rx_want.status));
                    if (out_priority !== rx_want.prio)
                        flag_mismatch($sformatf("out_priority got %0d want %0d",
                                                out_priority, rx_want.prio));
                    if (out_payload !== rx_want.data)
                        flag_mismatch($sformatf("out_payload got %0d want %0d",
                                                out_payload, rx_want.data));
                    if (occupancy !== rx_want.occ)
                        flag_mismatch($sformatf("occupancy got %0d want %0d",
                                                occupancy, rx_want.occ));
                end
                result_count++;
                rx_wait = ((result_count / 64) % 3 == 0) ? 0 : $urandom_range(0, 19);
            end
            else if (rx_wait > 0)
                rx_wait--;
            out_ready <= (rx_wait == 0) && !rx_hold;
        end
    end

    // Hold the receiver off once for a long stretch while the sender keeps
    // offering, so the block backs up and drops in_ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold        <= 1'b0;
            rx_hold_done   <= 1'b0;
            rx_hold_cycles <= 0;
        end
        else if (!rx_hold_done)
        begin
            if (!rx_hold)
            begin
                if (accepted_count >= HOLD_AFTER)
                    rx_hold <= 1'b1;
            end
            else if (rx_hold_cycles >= HOLD_CYCLES)
            begin
                rx_hold      <= 1'b0;
                rx_hold_done <= 1'b1;
            end
            else
                rx_hold_cycles <= rx_hold_cycles + 1;
        end
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL bounded_min_priority_queue");
            $finish;
        end
    end

    initial
    begin
        int      ph;
        int      k;
        int      kind;
        int      roll;
        bit      paced;
        op_t     op;
        logic [PRIO_W-1:0] prio;

        // Directed: remove from empty, extreme priorities and data words, ties
        // at both ends of the chain, fill to the brim, two inserts into a full
        // queue, then a few removes. The random phases follow.
        push_request(OP_REMOVE, 8'd0, 32'sd0, 0);
        push_request(OP_INSERT, 8'd255, 32'sh7fffffff, $urandom_range(0, 19));
        push_request(OP_INSERT, 8'd0, 32'sh80000000, 0);
        push_request(OP_INSERT, 8'd7, 32'sd1, 0);
        push_request(OP_INSERT, 8'd7, 32'sd2, $urandom_range(0, 19));
        push_request(OP_INSERT, 8'd0, -32'sd1, 0);
        push_request(OP_REMOVE, 8'd255, 32'sh7fffffff, 0);
        for (k = 0; k < 11; k++)
            push_request(OP_INSERT, 8'(k * 25), $urandom, $urandom_range(0, 3));
        push_request(OP_INSERT, 8'd7, 32'sd3, 0);
        push_request(OP_INSERT, 8'd0, 32'sd0, 0);
        push_request(OP_INSERT, 8'd255, -32'sd1, $urandom_range(0, 19));
        for (k = 0; k < 4; k++)
            push_request(OP_REMOVE, 8'($urandom), $urandom, $urandom_range(0, 5));

        // Random: phases of 40 requests that lean toward filling, draining,
        // a balanced mix, or heavy ties; some phases run with no sender gaps.
        for (ph = 0; ph < 20; ph++)
        begin
            kind  = $urandom_range(0, 3);
            paced = ($urandom_range(0, 2) != 0);
            for (k = 0; k < 40; k++)
            begin
                roll = $urandom_range(0, 99);
                case (kind)
                    0:       op = (roll < 75) ? OP_INSERT : OP_REMOVE;
                    1:       op = (roll < 25) ? OP_INSERT : OP_REMOVE;
                    default: op = (roll < 50) ? OP_INSERT : OP_REMOVE;
                endcase
                roll = $urandom_range(0, 9);
                if (kind == 3)
                    prio = 8'($urandom_range(0, 3));
                else if (roll == 0)
                    prio = 8'd0;
                else if (roll == 1)
                    prio = 8'd255;
                else
                    prio = 8'($urandom);
                push_request(op, prio, $urandom, paced ? $urandom_range(0, 19) : 0);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every request accepted and every owed result seen, then a short tail
        // to catch stray result transfers.
        while (outgoing_items.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && due_results.size() == 0)
            $display("PASS bounded_min_priority_queue");
        else
            $display("FAIL bounded_min_priority_queue");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bmpq_pkg.sv
rtl/core/bmpq_cell.sv
rtl/core/bounded_min_priority_queue.sv
rtl/core/bmpq_checker.sv
bench/tb_bounded_min_priority_queue.sv
